@@ src/adp_alu_pkg.sv @@
// Shared types and opcode constants for the data-processing execute stage.
`default_nettype none

package adp_alu_pkg;

   localparam logic [3:0] OP_AND = 4'h0;
   localparam logic [3:0] OP_EOR = 4'h1;
   localparam logic [3:0] OP_SUB = 4'h2;
   localparam logic [3:0] OP_RSB = 4'h3;
   localparam logic [3:0] OP_ADD = 4'h4;
   localparam logic [3:0] OP_ADC = 4'h5;
   localparam logic [3:0] OP_SBC = 4'h6;
   localparam logic [3:0] OP_RSC = 4'h7;
   localparam logic [3:0] OP_TST = 4'h8;
   localparam logic [3:0] OP_TEQ = 4'h9;
   localparam logic [3:0] OP_CMP = 4'hA;
   localparam logic [3:0] OP_CMN = 4'hB;
   localparam logic [3:0] OP_ORR = 4'hC;
   localparam logic [3:0] OP_MOV = 4'hD;
   localparam logic [3:0] OP_BIC = 4'hE;
   localparam logic [3:0] OP_MVN = 4'hF;

   localparam logic [1:0] SHIFT_LSL = 2'd0;
   localparam logic [1:0] SHIFT_LSR = 2'd1;
   localparam logic [1:0] SHIFT_ASR = 2'd2;
   localparam logic [1:0] SHIFT_ROR = 2'd3;

   localparam logic [3:0] REG_PC = 4'd15;

   typedef struct packed {
      logic [31:0] instr_word;
      logic [31:0] first_value;
      logic [31:0] shifted_value;
      logic [31:0] amount_value;
      logic [3:0]  flags_in;
   } req_data_type;

   typedef struct packed {
      logic [31:0] alu_result;
      logic        dest_write;
      logic [3:0]  dest_index;
      logic        pc_written;
      logic        restore_status;
      logic [3:0]  flags_out;
   } rsp_data_type;

   typedef struct packed {
      logic [31:0] operand;
      logic        carry;
   } shift_result_type;

endpackage

`default_nettype wire

@@ src/arm_data_processing_alu.sv @@
// Data-processing execute stage: input register, shifter and ALU, result register.
//
// One instruction enters on the req_ channel with the Rn, Rm and Rs values and
// the current NZCV flags; one result leaves on the rsp_ channel with the ALU
// result, write-back controls and the new flags.
// A transfer takes place on a rising edge with valid high and stall low.
// A request is loaded into the input register at its transfer, moves on
// into the result register once that register is free or being emptied,
// and is offered on the rsp_ channel from there.
// Throughput: one instruction per cycle while rsp_stall is low; the shifter
// and 32-bit adder sit in a single stage between the two registers.
// When rsp_stall is held, the result register holds its contents and the
// input register keeps taking one more item; req_stall rises only when both
// registers are full and the result is not being taken.
// Reset (synchronous, active high) empties both registers; no other state.
`default_nettype none

module arm_data_processing_alu import adp_alu_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire req_data_type req_data,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      rsp_data_type rsp_data
);

   logic             stage_valid_ff;
   logic             stage_valid_in;
   req_data_type     stage_data_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_data_type     rsp_data_ff;
   rsp_data_type     rsp_data_in;
   logic             load_out;

   shift_result_type shift_res;
   logic [31:0]      ins;
   logic [3:0]       opc;
   logic [3:0]       rd;
   logic             set_flags;
   logic             c_in;
   logic [31:0]      op1;
   logic [31:0]      op2;
   logic [31:0]      add_x;
   logic [31:0]      add_y;
   logic             add_c;
   logic [32:0]      sum;
   logic             arith;
   logic [31:0]      res;
   logic             flag_c;
   logic             flag_v;
   logic             writes;

   assign load_out  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = stage_valid_ff && !load_out;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   adp_alu_shifter u_shifter (
      .instr_word    (stage_data_ff.instr_word),
      .shifted_value (stage_data_ff.shifted_value),
      .amount_value  (stage_data_ff.amount_value),
      .carry_in      (stage_data_ff.flags_in[1]),
      .shift_out     (shift_res)
   );

   always_comb begin
      ins       = stage_data_ff.instr_word;
      opc       = ins[24:21];
      rd        = ins[15:12];
      set_flags = ins[20];
      c_in      = stage_data_ff.flags_in[1];
      op2       = shift_res.operand;
      // register-specified shift reads PC one word further on
      op1 = (ins[19:16] == REG_PC && !ins[25] && ins[4])
            ? stage_data_ff.first_value + 32'd4 : stage_data_ff.first_value;

      arith = 1'b0;
      add_x = op1;
      add_y = op2;
      add_c = 1'b0;
      res   = 32'd0;
      case (opc)
         OP_AND, OP_TST: res = op1 & op2;
         OP_EOR, OP_TEQ: res = op1 ^ op2;
         OP_SUB, OP_CMP: begin
            arith = 1'b1; add_y = ~op2; add_c = 1'b1;
         end
         OP_RSB: begin
            arith = 1'b1; add_x = op2; add_y = ~op1; add_c = 1'b1;
         end
         OP_ADD, OP_CMN: arith = 1'b1;
         OP_ADC: begin
            arith = 1'b1; add_c = c_in;
         end
         OP_SBC: begin
            arith = 1'b1; add_y = ~op2; add_c = c_in;
         end
         OP_RSC: begin
            arith = 1'b1; add_x = op2; add_y = ~op1; add_c = c_in;
         end
         OP_ORR: res = op1 | op2;
         OP_MOV: res = op2;
         OP_BIC: res = op1 & ~op2;
         default: res = ~op2;
      endcase

      sum    = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_c};
      flag_c = shift_res.carry;
      flag_v = stage_data_ff.flags_in[0];
      if (arith) begin
         res    = sum[31:0];
         flag_c = sum[32];
         flag_v = !(add_x[31] ^ add_y[31]) && (add_x[31] ^ sum[31]);
      end

      writes = !(opc == OP_TST || opc == OP_TEQ || opc == OP_CMP || opc == OP_CMN);

      rsp_data_in.alu_result     = res;
      rsp_data_in.dest_write     = writes;
      rsp_data_in.dest_index     = rd;
      rsp_data_in.pc_written     = writes && rd == REG_PC;
      rsp_data_in.restore_status = set_flags && rd == REG_PC;
      rsp_data_in.flags_out      = (set_flags && rd != REG_PC)
                                   ? {res[31], res == 32'd0, flag_c, flag_v}
                                   : stage_data_ff.flags_in;
   end

   always_comb begin
      stage_valid_in = req_stall ? stage_valid_ff : req_valid;
      rsp_valid_in   = load_out ? stage_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // hold payloads unless a transfer moves them on
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stage_data_ff <= req_data;
      end
      if (load_out && stage_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

@@ src/adp_alu_shifter.sv @@
// Barrel shifter: rotated immediate or shifted register operand with shifter carry.
`default_nettype none

module adp_alu_shifter import adp_alu_pkg::*; (
   input  wire logic [31:0]      instr_word,
   input  wire logic [31:0]      shifted_value,
   input  wire logic [31:0]      amount_value,
   input  wire logic             carry_in,
   output shift_result_type      shift_out
);

   logic [4:0]  imm_rot;
   logic [63:0] imm_pair;
   logic [31:0] imm_value;
   logic [1:0]  kind;
   logic        by_reg;
   logic [31:0] rm_val;
   logic [7:0]  amt_raw;
   logic [7:0]  amt;
   logic [5:0]  amt_clamp;
   logic [5:0]  amt_asr;
   logic [32:0] lsl_wide;
   logic [32:0] lsr_wide;
   logic [32:0] asr_wide;
   logic [63:0] ror_pair;

   always_comb begin
      imm_rot   = {instr_word[11:8], 1'b0};
      imm_pair  = {24'd0, instr_word[7:0], 24'd0, instr_word[7:0]} >> imm_rot;
      imm_value = imm_pair[31:0];

      kind    = instr_word[6:5];
      by_reg  = instr_word[4];
      rm_val  = (by_reg && instr_word[3:0] == REG_PC) ? shifted_value + 32'd4
                                                      : shifted_value;
      amt_raw = by_reg ? amount_value[7:0] : {3'd0, instr_word[11:7]};
      // immediate LSR/ASR by zero encode a shift by 32
      amt     = (amt_raw == 8'd0) ? 8'd32 : amt_raw;

      amt_clamp = (amt > 8'd32) ? 6'd33 : amt[5:0];
      amt_asr   = (amt > 8'd32) ? 6'd32 : amt[5:0];
      lsl_wide  = {1'b0, rm_val} << amt_clamp;
      lsr_wide  = {rm_val, 1'b0} >> amt_clamp;
      asr_wide  = 33'($signed({rm_val, 1'b0}) >>> amt_asr);
      ror_pair  = {rm_val, rm_val} >> amt[4:0];

      if (instr_word[25]) begin
         shift_out.operand = imm_value;
         shift_out.carry   = (imm_rot == 5'd0) ? carry_in : imm_value[31];
      end else if (amt_raw == 8'd0 && (by_reg || kind == SHIFT_LSL)) begin
         shift_out.operand = rm_val;
         shift_out.carry   = carry_in;
      end else if (amt_raw == 8'd0 && kind == SHIFT_ROR) begin
         // rotate right extended through carry
         shift_out.operand = {carry_in, rm_val[31:1]};
         shift_out.carry   = rm_val[0];
      end else begin
         case (kind)
            SHIFT_LSL: begin
               shift_out.operand = lsl_wide[31:0];
               shift_out.carry   = lsl_wide[32];
            end
            SHIFT_LSR: begin
               shift_out.operand = lsr_wide[32:1];
               shift_out.carry   = lsr_wide[0];
            end
            SHIFT_ASR: begin
               shift_out.operand = asr_wide[32:1];
               shift_out.carry   = asr_wide[0];
            end
            default: begin
               shift_out.operand = ror_pair[31:0];
               shift_out.carry   = ror_pair[31];
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/arm_data_processing_alu_tb.sv @@
// Self-checking testbench for the data-processing execute stage, shifter and ALU.
module arm_data_processing_alu_tb;
   import adp_alu_pkg::*;

   class alu_scoreboard;
      rsp_data_type expected_q[$];
      int errors = 0;
      int noted = 0;
      int checked = 0;

      // Barrel shifter: immediate rotate or Rm shifted by immediate or Rs amount.
      function automatic shift_result_type barrel_shift(logic [31:0] ins, logic [31:0] rm,
                                                        logic [31:0] rs, logic cin);
         shift_result_type r;
         logic [1:0] kind;
         logic [7:0] amt;
         logic [4:0] rot;
         logic [63:0] twice;
         int idx;
         kind = ins[6:5];
         if (ins[25]) begin
            rot = {ins[11:8], 1'b0};
            twice = {24'd0, ins[7:0], 24'd0, ins[7:0]};
            twice = twice >> rot;
            r.operand = twice[31:0];
            r.carry = (rot == 5'd0) ? cin : r.operand[31];
            return r;
         end
         if (ins[4] && ins[3:0] == REG_PC) rm = rm + 32'd4;
         amt = ins[4] ? rs[7:0] : {3'd0, ins[11:7]};
         if (amt == 8'd0) begin
            if (ins[4] || kind == SHIFT_LSL) begin
               r.operand = rm;
               r.carry = cin;
               return r;
            end
            if (kind == SHIFT_ROR) begin
               // RRX: carry in enters at the top
               r.operand = {cin, rm[31:1]};
               r.carry = rm[0];
               return r;
            end
            amt = 8'd32;
         end
         case (kind)
            SHIFT_LSL: begin
               if (amt < 8'd32) begin
                  idx = 32 - amt;
                  r.operand = rm << amt;
                  r.carry = rm[idx];
               end else begin
                  r.operand = '0;
                  r.carry = (amt == 8'd32) ? rm[0] : 1'b0;
               end
            end
            SHIFT_LSR: begin
               if (amt < 8'd32) begin
                  idx = amt - 1;
                  r.operand = rm >> amt;
                  r.carry = rm[idx];
               end else begin
                  r.operand = '0;
                  r.carry = (amt == 8'd32) ? rm[31] : 1'b0;
               end
            end
            SHIFT_ASR: begin
               if (amt < 8'd32) begin
                  idx = amt - 1;
                  r.operand = $signed(rm) >>> amt;
                  r.carry = rm[idx];
               end else begin
                  r.operand = {32{rm[31]}};
                  r.carry = rm[31];
               end
            end
            SHIFT_ROR: begin
               if (amt[4:0] == 5'd0) begin
                  r.operand = rm;
                  r.carry = rm[31];
               end else begin
                  twice = {rm, rm};
                  twice = twice >> amt[4:0];
                  r.operand = twice[31:0];
                  r.carry = r.operand[31];
               end
            end
         endcase
         return r;
      endfunction

      function automatic rsp_data_type execute_dp(req_data_type q);
         rsp_data_type o;
         shift_result_type sh;
         logic [31:0] op1, x, y, res;
         logic [32:0] sum;
         logic [3:0] opc, rn, rd;
         logic cin, ac, arith, s, wr, c, v;
         opc = q.instr_word[24:21];
         s = q.instr_word[20];
         rn = q.instr_word[19:16];
         rd = q.instr_word[15:12];
         cin = q.flags_in[1];
         sh = barrel_shift(q.instr_word, q.shifted_value, q.amount_value, cin);
         op1 = q.first_value;
         if (rn == REG_PC && !q.instr_word[25] && q.instr_word[4]) op1 = op1 + 32'd4;
         x = '0;
         y = '0;
         ac = 1'b0;
         arith = 1'b1;
         res = '0;
         case (opc)
            OP_AND, OP_TST: begin res = op1 & sh.operand; arith = 1'b0; end
            OP_EOR, OP_TEQ: begin res = op1 ^ sh.operand; arith = 1'b0; end
            OP_SUB, OP_CMP: begin x = op1; y = ~sh.operand; ac = 1'b1; end
            OP_RSB:         begin x = sh.operand; y = ~op1; ac = 1'b1; end
            OP_ADD, OP_CMN: begin x = op1; y = sh.operand; ac = 1'b0; end
            OP_ADC:         begin x = op1; y = sh.operand; ac = cin; end
            OP_SBC:         begin x = op1; y = ~sh.operand; ac = cin; end
            OP_RSC:         begin x = sh.operand; y = ~op1; ac = cin; end
            OP_ORR:         begin res = op1 | sh.operand; arith = 1'b0; end
            OP_MOV:         begin res = sh.operand; arith = 1'b0; end
            OP_BIC:         begin res = op1 & ~sh.operand; arith = 1'b0; end
            OP_MVN:         begin res = ~sh.operand; arith = 1'b0; end
         endcase
         c = sh.carry;
         v = q.flags_in[0];
         if (arith) begin
            sum = {1'b0, x} + {1'b0, y} + {32'd0, ac};
            res = sum[31:0];
            c = sum[32];
            v = (x[31] == y[31]) && (x[31] != res[31]);
         end
         wr = !(opc == OP_TST || opc == OP_TEQ || opc == OP_CMP || opc == OP_CMN);
         o.alu_result = res;
         o.dest_write = wr;
         o.dest_index = rd;
         o.pc_written = wr && rd == REG_PC;
         o.restore_status = s && rd == REG_PC;
         o.flags_out = (s && rd != REG_PC) ? {res[31], res == 32'd0, c, v} : q.flags_in;
         return o;
      endfunction

      function void note_instr(req_data_type q);
         expected_q.push_back(execute_dp(q));
         noted++;
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_data_type got);
         rsp_data_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: result with nothing pending: expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare("alu_result", want.alu_result, got.alu_result);
         compare("dest_write", 32'(want.dest_write), 32'(got.dest_write));
         compare("dest_index", 32'(want.dest_index), 32'(got.dest_index));
         compare("pc_written", 32'(want.pc_written), 32'(got.pc_written));
         compare("restore_status", 32'(want.restore_status), 32'(got.restore_status));
         compare("flags_out", 32'(want.flags_out), 32'(got.flags_out));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_data_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_data_type rsp_data;

   alu_scoreboard sb;
   bit sender_quiet = 1'b0;
   bit hold_off_pending = 1'b0;
   int directed_count = 0;
   int random_count = 0;

   arm_data_processing_alu dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_instr(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 11))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] dp_word(logic imm, logic [3:0] opc, logic s,
                                           logic [3:0] rn, logic [3:0] rd, logic [11:0] op2);
      return {4'hE, 2'b00, imm, opc, s, rn, rd, op2};
   endfunction

   function automatic logic [11:0] imm_shift(logic [4:0] amt, logic [1:0] kind, logic [3:0] rm);
      return {amt, kind, 1'b0, rm};
   endfunction

   function automatic logic [11:0] reg_shift(logic [3:0] rs, logic [1:0] kind, logic [3:0] rm);
      return {rs, 1'b0, kind, 1'b1, rm};
   endfunction

   // Offer one instruction and hold it until the transfer.
   task automatic send_instr(logic [31:0] w, logic [31:0] rn_val, logic [31:0] rm_val,
                             logic [31:0] rs_val, logic [3:0] flags);
      int gap;
      req_valid <= 1'b1;
      req_data <= '{instr_word: w, first_value: rn_val, shifted_value: rm_val,
                    amount_value: rs_val, flags_in: flags};
      do @(posedge clock); while (req_stall);
      gap = sender_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random();
      logic [31:0] w, rs;
      w = $urandom();
      rs = $urandom();
      case ($urandom_range(0, 7))
         0: w[15:12] = REG_PC;
         1: begin
            // PC read under a register-specified shift
            w[25] = 1'b0;
            w[4] = 1'b1;
            if ($urandom_range(0, 1)) w[3:0] = REG_PC;
            if ($urandom_range(0, 1)) w[19:16] = REG_PC;
         end
         2: begin
            w[25] = 1'b0;
            w[4] = 1'b0;
            w[11:7] = 5'd0;
         end
         3, 4: begin
            w[25] = 1'b0;
            w[4] = 1'b1;
            rs[7:0] = 8'($urandom_range(0, 40));
         end
         default: ;
      endcase
      send_instr(w, pick_word(), pick_word(), rs, 4'($urandom_range(0, 15)));
   endtask

   // Result side: random stall bursts, free stretches, and one long hold-off.
   initial begin : result_sink
      int stall_len;
      int free_len;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            stall_len = 300;
            hold_off_pending = 1'b0;
         end else begin
            stall_len = pick_gap();
         end
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 10);
         repeat (free_len) @(posedge clock);
      end
   end

   initial begin : stimulus
      int k;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Immediate operand: no rotation keeps C, a rotation takes bit 31.
      send_instr(dp_word(1'b1, OP_MOV, 1'b1, 4'd0, 4'd1, 12'h0FF), 32'h0, 32'h0, 32'h0, 4'b0010);
      send_instr(dp_word(1'b1, OP_MOV, 1'b1, 4'd0, 4'd1, 12'h4FF), 32'h0, 32'h0, 32'h0, 4'b0000);
      send_instr(dp_word(1'b1, OP_MVN, 1'b1, 4'd0, 4'd2, 12'hF80), 32'h0, 32'h0, 32'h0, 4'b1111);
      // Immediate shift amount zero: LSL passes, LSR/ASR mean 32, ROR means RRX.
      send_instr(dp_word(1'b0, OP_ADD, 1'b1, 4'd1, 4'd3, imm_shift(5'd0, SHIFT_LSL, 4'd2)),
                 32'h1, 32'hFFFF_FFFF, 32'h0, 4'b0010);
      send_instr(dp_word(1'b0, OP_SUB, 1'b1, 4'd1, 4'd3, imm_shift(5'd0, SHIFT_LSR, 4'd2)),
                 32'h0, 32'h8000_0000, 32'h0, 4'b0000);
      send_instr(dp_word(1'b0, OP_RSB, 1'b1, 4'd1, 4'd3, imm_shift(5'd0, SHIFT_ASR, 4'd2)),
                 32'h5, 32'h8000_0000, 32'h0, 4'b0001);
      send_instr(dp_word(1'b0, OP_EOR, 1'b1, 4'd1, 4'd3, imm_shift(5'd0, SHIFT_ROR, 4'd2)),
                 32'h0, 32'h0000_0003, 32'h0, 4'b0010);
      // Register amounts: 32, above 32, 255, multiple of 32 for ROR, zero.
      send_instr(dp_word(1'b0, OP_ADC, 1'b1, 4'd4, 4'd5, reg_shift(4'd6, SHIFT_LSL, 4'd7)),
                 32'h0, 32'h0000_0001, 32'h20, 4'b0010);
      send_instr(dp_word(1'b0, OP_SBC, 1'b1, 4'd4, 4'd5, reg_shift(4'd6, SHIFT_LSR, 4'd7)),
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h121, 4'b0000);
      send_instr(dp_word(1'b0, OP_RSC, 1'b1, 4'd4, 4'd5, reg_shift(4'd6, SHIFT_ASR, 4'd7)),
                 32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 4'b0010);
      send_instr(dp_word(1'b0, OP_TST, 1'b1, 4'd4, 4'd5, reg_shift(4'd6, SHIFT_ROR, 4'd7)),
                 32'hFFFF_FFFF, 32'h8000_0001, 32'h40, 4'b0000);
      send_instr(dp_word(1'b0, OP_TEQ, 1'b1, 4'd4, 4'd5, reg_shift(4'd6, SHIFT_LSL, 4'd7)),
                 32'h1234_5678, 32'h1234_5678, 32'h100, 4'b0010);
      send_instr(dp_word(1'b0, OP_ORR, 1'b1, 4'd4, 4'd5, reg_shift(4'd6, SHIFT_ROR, 4'd7)),
                 32'h0, 32'h0000_0001, 32'h1F, 4'b0000);
      // PC as Rm and Rn under a register shift reads 4 further on.
      send_instr(dp_word(1'b0, OP_CMP, 1'b1, REG_PC, 4'd0, reg_shift(4'd1, SHIFT_LSL, REG_PC)),
                 32'h0000_1000, 32'h0000_0800, 32'h1, 4'b0000);
      send_instr(dp_word(1'b0, OP_ADD, 1'b1, REG_PC, 4'd8, reg_shift(4'd1, SHIFT_LSR, REG_PC)),
                 32'hFFFF_FFFC, 32'hFFFF_FFFC, 32'h0, 4'b0000);
      // Overflow, borrow and zero.
      send_instr(dp_word(1'b0, OP_CMN, 1'b1, 4'd1, 4'd0, imm_shift(5'd0, SHIFT_LSL, 4'd2)),
                 32'h7FFF_FFFF, 32'h1, 32'h0, 4'b0000);
      send_instr(dp_word(1'b0, OP_ADD, 1'b1, 4'd1, 4'd9, imm_shift(5'd0, SHIFT_LSL, 4'd2)),
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 4'b0000);
      send_instr(dp_word(1'b0, OP_SUB, 1'b1, 4'd1, 4'd9, imm_shift(5'd0, SHIFT_LSL, 4'd2)),
                 32'h0, 32'h1, 32'h0, 4'b1111);
      send_instr(dp_word(1'b0, OP_AND, 1'b1, 4'd1, 4'd9, imm_shift(5'd31, SHIFT_LSL, 4'd2)),
                 32'h0, 32'hFFFF_FFFF, 32'h0, 4'b1011);
      send_instr(dp_word(1'b0, OP_BIC, 1'b1, 4'd1, 4'd9, imm_shift(5'd31, SHIFT_ASR, 4'd2)),
                 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 4'b0000);
      // Test opcode without S leaves everything alone.
      send_instr(dp_word(1'b0, OP_CMP, 1'b0, 4'd1, 4'd9, imm_shift(5'd1, SHIFT_LSR, 4'd2)),
                 32'h5, 32'h5, 32'h0, 4'b1010);
      // Rd is PC: with S restore status, without S only flush.
      send_instr(dp_word(1'b0, OP_ORR, 1'b1, 4'd1, REG_PC, imm_shift(5'd0, SHIFT_LSL, 4'd2)),
                 32'h0, 32'h0, 32'h0, 4'b0101);
      send_instr(dp_word(1'b0, OP_RSC, 1'b1, 4'd1, REG_PC, imm_shift(5'd4, SHIFT_ROR, 4'd2)),
                 32'h8, 32'h10, 32'h0, 4'b0110);
      send_instr(dp_word(1'b1, OP_BIC, 1'b0, 4'd1, REG_PC, 12'h3FF), 32'hFFFF_FFFF, 32'h0,
                 32'h0, 4'b0011);
      send_instr(dp_word(1'b1, OP_TEQ, 1'b1, 4'd1, REG_PC, 12'h001), 32'h1, 32'h0, 32'h0,
                 4'b1001);
      directed_count = 25;

      for (k = 0; k < 1400; k++) begin
         if (k == 600) hold_off_pending = 1'b1;
         // No idling on the input while the result side holds off, and in some stretches.
         sender_quiet = (k >= 600 && k < 700) || ((k / 200) % 3 == 1);
         send_random();
         random_count++;
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Ran %0d directed and %0d random instructions; %0d taken in, %0d checked.",
               directed_count, random_count, sb.noted, sb.checked);
      $display("Covered all opcodes, shift kinds and amounts, PC operands and a long hold-off.");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
